// ===== src/worker_pool_dispatcher_assert.svh =====
// assertion macros shared by the dispatcher modules
`ifndef WORKER_POOL_DISPATCHER_ASSERT_SVH
`define WORKER_POOL_DISPATCHER_ASSERT_SVH
`ifndef ASSERT_OFF
`define WPD_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);
`define WPD_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) else $error(msg);
`else
`define WPD_ASSERT(lbl, prop, msg)
`define WPD_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

// ===== src/wpd_pkg.sv =====
package wpd_pkg;

    localparam int FUNC_W     = 2;
    localparam int TAG_W      = 16;
    localparam int WID_W      = 4;
    localparam int NUM_IDS    = 16;
    localparam int CFG_W      = 5;
    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;

    localparam logic [CFG_W-1:0] MAX_WORKERS_RESET = 5'd4;

    // register index taken from paddr above the byte offset
    localparam logic [APB_ADDR_W-3:0] REG_MAX_WORKERS = 1'b0;

    localparam logic [FUNC_W-1:0] FN_SUBMIT   = 2'd0;
    localparam logic [FUNC_W-1:0] FN_FINISHED = 2'd1;
    localparam logic [FUNC_W-1:0] FN_SHUTDOWN = 2'd2;

    typedef enum logic [2:0] {
        ST_TO_IDLE  = 3'd0,
        ST_TO_NEW   = 3'd1,
        ST_QUEUED   = 3'd2,
        ST_REJECTED = 3'd3,
        ST_IDLED    = 3'd4,
        ST_IGNORED  = 3'd5,
        ST_ABORTED  = 3'd6,
        ST_DONE     = 3'd7
    } t_status;

    typedef enum logic [1:0] {
        W_ZERO  = 2'd0,
        W_STACK = 2'd1,
        W_COUNT = 2'd2,
        W_WID   = 2'd3
    } t_wsel;

    typedef enum logic [1:0] {
        T_ZERO = 2'd0,
        T_IN   = 2'd1,
        T_FIFO = 2'd2
    } t_tsel;

    typedef struct packed {
        logic    in_ready;
        logic    emit;
        t_status status;
        t_wsel   wsel;
        t_tsel   tsel;
        logic    last;
        logic    pop_idle;
        logic    create;
        logic    push_q;
        logic    pop_q;
        logic    push_idle;
        logic    clear_all;
        logic    set_stop;
    } t_dp_cmd;

    typedef struct packed {
        logic              in_accept;
        logic [FUNC_W-1:0] func;
        logic              stopping;
        logic              present;
        logic              q_full;
        logic              q_nonempty;
        logic              q_one;
        logic              idle_nonempty;
        logic              stack_room;
        logic              can_create;
        logic              wid_bad;
        logic              slot_free;
    } t_dp_stat;

endpackage

// ===== src/wpd_if.sv =====
interface wpd_req_if import wpd_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [FUNC_W-1:0] func;
    logic [TAG_W-1:0]  request_tag;
    logic              target_present;
    logic [WID_W-1:0]  worker_id;

    modport source (
        output valid, func, request_tag, target_present, worker_id,
        input  ready
    );
    modport sink (
        input  valid, func, request_tag, target_present, worker_id,
        output ready
    );
endinterface

interface wpd_rsp_if import wpd_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [2:0]       status;
    logic [WID_W-1:0] out_worker;
    logic [TAG_W-1:0] out_tag;
    logic             last;

    modport source (
        output valid, status, out_worker, out_tag, last,
        input  ready
    );
    modport sink (
        input  valid, status, out_worker, out_tag, last,
        output ready
    );
endinterface

// ===== src/wpd_ctrl.sv =====
`include "worker_pool_dispatcher_assert.svh"

module wpd_ctrl import wpd_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_dp_stat i_stat,
    output t_dp_cmd  o_cmd
);

    typedef enum logic [1:0] {
        S_IDLE  = 2'd0,
        S_EXEC  = 2'd1,
        S_DRAIN = 2'd2
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_in_ready;

    always_comb begin
        n_state        = r_state;
        o_cmd          = '0;
        o_cmd.in_ready = r_in_ready;
        o_cmd.status   = ST_IGNORED;
        o_cmd.wsel     = W_ZERO;
        o_cmd.tsel     = T_ZERO;
        case (r_state)
            S_IDLE: begin
                if (i_stat.in_accept) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                if (i_stat.slot_free) begin
                    o_cmd.emit = 1'b1;
                    o_cmd.last = 1'b1;
                    n_state    = S_IDLE;
                    case (i_stat.func)
                        FN_SUBMIT: begin
                            o_cmd.tsel = T_IN;
                            if (i_stat.stopping || !i_stat.present || i_stat.q_full) begin
                                o_cmd.status = ST_REJECTED;
                            end else if (i_stat.idle_nonempty) begin
                                o_cmd.status   = ST_TO_IDLE;
                                o_cmd.wsel     = W_STACK;
                                o_cmd.pop_idle = 1'b1;
                            end else if (i_stat.can_create) begin
                                o_cmd.status = ST_TO_NEW;
                                o_cmd.wsel   = W_COUNT;
                                o_cmd.create = 1'b1;
                            end else begin
                                o_cmd.status = ST_QUEUED;
                                o_cmd.push_q = 1'b1;
                            end
                        end
                        FN_FINISHED: begin
                            if (i_stat.wid_bad) begin
                                o_cmd.status = ST_IGNORED;
                            end else if (i_stat.q_nonempty) begin
                                // oldest queued word goes straight to the reporting worker
                                o_cmd.status = ST_TO_IDLE;
                                o_cmd.wsel   = W_WID;
                                o_cmd.tsel   = T_FIFO;
                                o_cmd.pop_q  = 1'b1;
                            end else if (i_stat.stack_room) begin
                                o_cmd.status    = ST_IDLED;
                                o_cmd.wsel      = W_WID;
                                o_cmd.push_idle = 1'b1;
                            end else begin
                                o_cmd.status = ST_IGNORED;
                            end
                        end
                        FN_SHUTDOWN: begin
                            if (i_stat.stopping) begin
                                o_cmd.status = ST_DONE;
                            end else if (i_stat.q_nonempty) begin
                                o_cmd.emit = 1'b0;
                                o_cmd.last = 1'b0;
                                n_state    = S_DRAIN;
                            end else begin
                                o_cmd.status    = ST_DONE;
                                o_cmd.clear_all = 1'b1;
                                o_cmd.set_stop  = 1'b1;
                            end
                        end
                        default: begin
                            o_cmd.status = ST_IGNORED;
                        end
                    endcase
                end
            end
            S_DRAIN: begin
                // one abort per cycle while the output slot is free, the final one carries last and clears the pool
                if (i_stat.slot_free) begin
                    o_cmd.emit   = 1'b1;
                    o_cmd.status = ST_ABORTED;
                    o_cmd.tsel   = T_FIFO;
                    o_cmd.pop_q  = 1'b1;
                    o_cmd.last   = i_stat.q_one;
                    if (i_stat.q_one) begin
                        o_cmd.clear_all = 1'b1;
                        o_cmd.set_stop  = 1'b1;
                        n_state         = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_in_ready <= 1'b1;
        end else begin
            r_state    <= n_state;
            r_in_ready <= (n_state == S_IDLE);
        end
    end

    `WPD_ASSERT(a_ready_only_idle, r_in_ready |-> r_state == S_IDLE, "ready outside idle")
    `WPD_ASSERT(a_drain_has_work, r_state == S_DRAIN |-> i_stat.q_nonempty, "drain on empty queue")
    `WPD_ASSERT_NEXT(a_accept_to_exec, i_stat.in_accept, r_state == S_EXEC, "accept not executed")

endmodule

// ===== src/wpd_dpath.sv =====
`include "worker_pool_dispatcher_assert.svh"

module wpd_dpath import wpd_pkg::*; #(
    parameter int QUEUE_DEPTH = 64,
    parameter int MAX_WORKERS = 16
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic [CFG_W-1:0] i_max_workers,
    input  t_dp_cmd          i_cmd,
    output t_dp_stat         o_stat,
    wpd_req_if.sink          i_req,
    wpd_rsp_if.source        o_rsp
);

    // worker ids are four bits wide, so no more than NUM_IDS can ever be idle at once
    localparam int STACK_DEPTH = (MAX_WORKERS < NUM_IDS) ? MAX_WORKERS : NUM_IDS;
    localparam int SCW   = $clog2(STACK_DEPTH + 1);
    localparam int SAW   = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
    localparam int WCW   = $clog2(MAX_WORKERS + 1);
    localparam int QAW   = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCW   = $clog2(QUEUE_DEPTH + 1);
    localparam int CMP_W = 8;

    // latched input word
    logic [FUNC_W-1:0] r_func;
    logic [TAG_W-1:0]  r_tag;
    logic              r_present;
    logic [WID_W-1:0]  r_wid;

    logic               r_stopping;
    logic [WCW-1:0]     r_worker_count;
    logic [SCW-1:0]     r_idle_count;
    logic [NUM_IDS-1:0] r_idle_flag;
    logic [WID_W-1:0]   r_idle_stack [STACK_DEPTH];

    logic [TAG_W-1:0]   r_q_mem [QUEUE_DEPTH];
    logic [TAG_W-1:0]   r_q_rdata;
    logic [QAW-1:0]     r_head;
    logic [QAW-1:0]     r_tail;
    logic [QCW-1:0]     r_q_count;

    logic               r_out_valid;
    t_status            r_out_status;
    logic [WID_W-1:0]   r_out_worker;
    logic [TAG_W-1:0]   r_out_tag;
    logic               r_out_last;

    logic               in_accept;
    logic               slot_free;
    logic [CMP_W-1:0]   limit;
    logic [SCW-1:0]     idle_dec;
    logic [WID_W-1:0]   stack_top;
    logic [QAW-1:0]     head_inc;
    logic [QAW-1:0]     tail_inc;
    logic [QAW-1:0]     rd_addr;
    logic [WID_W-1:0]   sel_worker;
    logic [TAG_W-1:0]   sel_tag;

    assign i_req.ready = i_cmd.in_ready;
    assign in_accept   = i_req.valid && i_cmd.in_ready;
    assign slot_free   = !r_out_valid || o_rsp.ready;

    always_comb begin
        if (i_max_workers == '0) begin
            limit = CMP_W'(1);
        end else if (CMP_W'(i_max_workers) > CMP_W'(MAX_WORKERS)) begin
            limit = CMP_W'(MAX_WORKERS);
        end else begin
            limit = CMP_W'(i_max_workers);
        end
    end

    assign idle_dec  = r_idle_count - SCW'(1);
    assign stack_top = r_idle_stack[idle_dec[SAW-1:0]];

    assign head_inc = (r_head == QAW'(QUEUE_DEPTH - 1)) ? '0 : r_head + QAW'(1);
    assign tail_inc = (r_tail == QAW'(QUEUE_DEPTH - 1)) ? '0 : r_tail + QAW'(1);
    // read ahead so the new head word is ready the cycle after a pop
    assign rd_addr  = i_cmd.pop_q ? head_inc : r_head;

    always_comb begin
        o_stat               = '0;
        o_stat.in_accept     = in_accept;
        o_stat.func          = r_func;
        o_stat.stopping      = r_stopping;
        o_stat.present       = r_present;
        o_stat.q_full        = (r_q_count == QCW'(QUEUE_DEPTH));
        o_stat.q_nonempty    = (r_q_count != '0);
        o_stat.q_one         = (r_q_count == QCW'(1));
        o_stat.idle_nonempty = (r_idle_count != '0);
        o_stat.stack_room    = (r_idle_count < SCW'(STACK_DEPTH));
        o_stat.can_create    = (CMP_W'(r_worker_count) < limit);
        o_stat.wid_bad       = r_stopping || (CMP_W'(r_wid) >= CMP_W'(r_worker_count))
                               || r_idle_flag[r_wid];
        o_stat.slot_free     = slot_free;
    end

    always_comb begin
        case (i_cmd.wsel)
            W_ZERO:  sel_worker = '0;
            W_STACK: sel_worker = stack_top;
            W_COUNT: sel_worker = WID_W'(r_worker_count);
            W_WID:   sel_worker = r_wid;
            default: sel_worker = '0;
        endcase
        case (i_cmd.tsel)
            T_ZERO:  sel_tag = '0;
            T_IN:    sel_tag = r_tag;
            T_FIFO:  sel_tag = r_q_rdata;
            default: sel_tag = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_func    <= i_req.func;
            r_tag     <= i_req.request_tag;
            r_present <= i_req.target_present;
            r_wid     <= i_req.worker_id;
        end
        if (i_cmd.emit) begin
            r_out_status <= i_cmd.status;
            r_out_worker <= sel_worker;
            r_out_tag    <= sel_tag;
            r_out_last   <= i_cmd.last;
        end
        if (i_cmd.push_idle) begin
            r_idle_stack[r_idle_count[SAW-1:0]] <= r_wid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.push_q) begin
            r_q_mem[r_tail] <= r_tag;
        end
        r_q_rdata <= r_q_mem[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stopping     <= 1'b0;
            r_worker_count <= '0;
            r_idle_count   <= '0;
            r_idle_flag    <= '0;
            r_head         <= '0;
            r_tail         <= '0;
            r_q_count      <= '0;
            r_out_valid    <= 1'b0;
        end else begin
            if (i_cmd.set_stop) begin
                r_stopping <= 1'b1;
            end
            if (i_cmd.clear_all) begin
                r_worker_count <= '0;
                r_idle_count   <= '0;
                r_idle_flag    <= '0;
                r_head         <= '0;
                r_tail         <= '0;
                r_q_count      <= '0;
            end else begin
                if (i_cmd.create) begin
                    r_worker_count <= r_worker_count + WCW'(1);
                end
                if (i_cmd.pop_idle) begin
                    r_idle_count           <= idle_dec;
                    r_idle_flag[stack_top] <= 1'b0;
                end else if (i_cmd.push_idle) begin
                    r_idle_count       <= r_idle_count + SCW'(1);
                    r_idle_flag[r_wid] <= 1'b1;
                end
                if (i_cmd.push_q) begin
                    r_tail    <= tail_inc;
                    r_q_count <= r_q_count + QCW'(1);
                end else if (i_cmd.pop_q) begin
                    r_head    <= head_inc;
                    r_q_count <= r_q_count - QCW'(1);
                end
            end
            if (i_cmd.emit) begin
                r_out_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_rsp.valid      = r_out_valid;
    assign o_rsp.status     = r_out_status;
    assign o_rsp.out_worker = r_out_worker;
    assign o_rsp.out_tag    = r_out_tag;
    assign o_rsp.last       = r_out_last;

    `WPD_ASSERT(a_flags_match_count, $countones(r_idle_flag) == int'(r_idle_count), "idle flags out of step")
    `WPD_ASSERT(a_queue_bound, r_q_count <= QCW'(QUEUE_DEPTH), "queue count overflow")
    `WPD_ASSERT_NEXT(a_clear_empties, i_cmd.clear_all, r_worker_count == '0 && r_q_count == '0 && r_stopping, "shutdown left state")

endmodule

// ===== src/worker_pool_dispatcher.sv =====
// Worker pool dispatcher: each input word (submit, finished or shutdown) is taken when
// i_req.ready is high and is worked out in the next cycle if the output register is free,
// else as soon as it frees; i_req.ready rises again only after that, so a word is not taken
// before the last one has been worked out. The next word is accepted even while
// that result still waits on o_rsp, and a result left waiting only holds back the working
// out of that next word. A shutdown with n queued tags gives n aborts at one per cycle
// while o_rsp keeps taking them; the pending queue memory has a single read port and is read
// one word ahead of its head. Idle workers are kept on a LIFO stack, waiting tags in a
// circular queue of QUEUE_DEPTH words; neither needs a clearing pass after reset.
// max_workers sits at byte address 0 of the APB port and should only be written while the
// block is idle.
`include "worker_pool_dispatcher_assert.svh"

module worker_pool_dispatcher import wpd_pkg::*; #(
    parameter int QUEUE_DEPTH = 64,
    parameter int MAX_WORKERS = 16
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    wpd_req_if.sink               i_req,
    wpd_rsp_if.source             o_rsp,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready
);

    logic [CFG_W-1:0] r_max_workers;
    logic             cfg_wr;
    t_dp_cmd          cmd;
    t_dp_stat         stat;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite
                    && (paddr[APB_ADDR_W-1:2] == REG_MAX_WORKERS);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_workers <= MAX_WORKERS_RESET;
        end else if (cfg_wr) begin
            r_max_workers <= pwdata[CFG_W-1:0];
        end
    end

    always_comb begin
        if (paddr[APB_ADDR_W-1:2] == REG_MAX_WORKERS) begin
            prdata = APB_DATA_W'(r_max_workers);
        end else begin
            prdata = '0;
        end
    end

    wpd_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_stat  (stat),
        .o_cmd   (cmd)
    );

    wpd_dpath #(
        .QUEUE_DEPTH (QUEUE_DEPTH),
        .MAX_WORKERS (MAX_WORKERS)
    ) u_dpath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_max_workers (r_max_workers),
        .i_cmd         (cmd),
        .o_stat        (stat),
        .i_req         (i_req),
        .o_rsp         (o_rsp)
    );

    // a waiting result is never overwritten
    `WPD_ASSERT(a_no_overwrite, o_rsp.valid && !o_rsp.ready |=> o_rsp.valid && $stable(o_rsp.out_tag), "result dropped")

endmodule

// ===== tb/worker_pool_dispatcher_tb.sv =====
module worker_pool_dispatcher_tb;
    import wpd_pkg::*;

    localparam int QDEPTH = 64;
    localparam logic [FUNC_W-1:0] FN_UNDEF = 2'd3;

    typedef struct packed {
        logic [FUNC_W-1:0] func;
        logic [TAG_W-1:0]  tag;
        logic              present;
        logic [WID_W-1:0]  wid;
    } req_word_t;

    typedef struct packed {
        t_status          status;
        logic [WID_W-1:0] worker;
        logic [TAG_W-1:0] tag;
        logic             last;
    } rsp_word_t;

    typedef struct packed {
        logic [CFG_W-1:0]              max_workers;
        logic                          stopping;
        logic [4:0]                    n_workers;
        logic [4:0]                    n_idle;
        logic [NUM_IDS-1:0][WID_W-1:0] idle_stack;
        logic [6:0]                    n_pending;
        logic [5:0]                    head;
        logic [5:0]                    tail;
        logic [QDEPTH-1:0][TAG_W-1:0]  backlog;
    } pool_state_t;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    logic                  psel = 1'b0;
    logic                  penable = 1'b0;
    logic                  pwrite = 1'b0;
    logic [APB_ADDR_W-1:0] paddr = '0;
    logic [APB_DATA_W-1:0] pwdata = '0;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    wpd_req_if req_bus ();
    wpd_rsp_if rsp_bus ();

    logic      drv_valid = 1'b0;
    logic      drv_ready = 1'b0;
    req_word_t cur_word = '0;

    assign req_bus.valid          = drv_valid;
    assign req_bus.func           = cur_word.func;
    assign req_bus.request_tag    = cur_word.tag;
    assign req_bus.target_present = cur_word.present;
    assign req_bus.worker_id      = cur_word.wid;
    assign rsp_bus.ready          = drv_ready;

    worker_pool_dispatcher u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_bus),
        .o_rsp   (rsp_bus),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // pool_live follows accepted words, pool_plan runs ahead as words are queued
    pool_state_t pool_live;
    pool_state_t pool_plan;
    req_word_t   req_words[$];
    rsp_word_t   owed_results[$];
    rsp_word_t   step_out[$];

    int send_gap_pct = 31;
    int recv_stall_pct = 46;
    int n_errors = 0;
    int n_accepted = 0;
    int n_checked = 0;
    int n_aborted = 0;
    int peak_backlog = 0;

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    function automatic void dispatch_word(inout pool_state_t s, input req_word_t w);
        logic [4:0]         limit;
        logic               bad;
        logic [NUM_IDS-1:0] idle_mask;
        rsp_word_t          r;
        int                 n_out;
        n_out = 0;
        r.status = ST_IGNORED;
        r.worker = '0;
        r.tag = '0;
        r.last = 1'b1;
        if (s.max_workers == 0)
            limit = 5'd1;
        else if (s.max_workers > NUM_IDS)
            limit = 5'(NUM_IDS);
        else
            limit = s.max_workers;
        case (w.func)
            FN_SUBMIT: begin
                r.tag = w.tag;
                if (s.stopping || !w.present || s.n_pending >= QDEPTH) begin
                    r.status = ST_REJECTED;
                end else if (s.n_idle != 0) begin
                    s.n_idle = s.n_idle - 1'b1;
                    r.status = ST_TO_IDLE;
                    r.worker = s.idle_stack[s.n_idle[3:0]];
                end else if (s.n_workers < limit) begin
                    r.status = ST_TO_NEW;
                    r.worker = s.n_workers[3:0];
                    s.n_workers = s.n_workers + 1'b1;
                end else begin
                    s.backlog[s.tail] = w.tag;
                    s.tail = s.tail + 1'b1;
                    s.n_pending = s.n_pending + 1'b1;
                    r.status = ST_QUEUED;
                end
                step_out.push_back(r);
            end
            FN_FINISHED: begin
                idle_mask = '0;
                for (int i = 0; i < NUM_IDS; i++)
                    if (i < s.n_idle) idle_mask[s.idle_stack[i]] = 1'b1;
                bad = s.stopping || (w.wid >= s.n_workers) || idle_mask[w.wid];
                if (!bad && s.n_pending != 0) begin
                    r.status = ST_TO_IDLE;
                    r.worker = w.wid;
                    r.tag = s.backlog[s.head];
                    s.head = s.head + 1'b1;
                    s.n_pending = s.n_pending - 1'b1;
                end else if (!bad && s.n_idle < NUM_IDS) begin
                    s.idle_stack[s.n_idle[3:0]] = w.wid;
                    s.n_idle = s.n_idle + 1'b1;
                    r.status = ST_IDLED;
                    r.worker = w.wid;
                end
                step_out.push_back(r);
            end
            FN_SHUTDOWN: begin
                if (!s.stopping) begin
                    s.stopping = 1'b1;
                    // every waiting tag is aborted in order, the last one closes the burst
                    while (s.n_pending != 0) begin
                        r.status = ST_ABORTED;
                        r.tag = s.backlog[s.head];
                        s.head = s.head + 1'b1;
                        s.n_pending = s.n_pending - 1'b1;
                        r.last = (s.n_pending == 0);
                        step_out.push_back(r);
                        n_out++;
                    end
                    s.head = '0;
                    s.tail = '0;
                    s.n_idle = '0;
                    s.n_workers = '0;
                end
                if (n_out == 0) begin
                    r.status = ST_DONE;
                    r.tag = '0;
                    r.last = 1'b1;
                    step_out.push_back(r);
                end
            end
            default: step_out.push_back(r);
        endcase
    endfunction

    task automatic push_word(input logic [FUNC_W-1:0] func, input logic [TAG_W-1:0] tag,
                             input logic present, input logic [WID_W-1:0] wid);
        req_word_t w;
        w.func = func;
        w.tag = tag;
        w.present = present;
        w.wid = wid;
        req_words.push_back(w);
        dispatch_word(pool_plan, w);
        step_out.delete();
    endtask

    task automatic queue_random_words(input int count);
        req_word_t          w;
        int                 submit_pct;
        int                 roll;
        int                 busy[$];
        logic [NUM_IDS-1:0] idle_mask;
        submit_pct = 50;
        for (int n = 0; n < count; n++) begin
            if (n % 20 == 0) begin
                // bursts lean towards submits or finishes so the backlog fills and drains
                case ($urandom_range(2))
                    0: submit_pct = 25;
                    1: submit_pct = 50;
                    default: submit_pct = 80;
                endcase
            end
            roll = $urandom_range(99);
            w.tag = TAG_W'($urandom);
            w.present = ($urandom_range(99) >= 6);
            w.wid = WID_W'($urandom);
            if (roll < 3) begin
                w.func = FN_UNDEF;
            end else if (roll < 3 + submit_pct) begin
                w.func = FN_SUBMIT;
            end else begin
                w.func = FN_FINISHED;
                idle_mask = '0;
                for (int i = 0; i < NUM_IDS; i++)
                    if (i < pool_plan.n_idle) idle_mask[pool_plan.idle_stack[i]] = 1'b1;
                busy.delete();
                for (int i = 0; i < NUM_IDS; i++)
                    if (i < pool_plan.n_workers && !idle_mask[i]) busy.push_back(i);
                // mostly a worker that is really busy, now and then a stray id
                if (busy.size() != 0 && $urandom_range(99) < 85)
                    w.wid = WID_W'(busy[$urandom_range(busy.size() - 1)]);
            end
            push_word(w.func, w.tag, w.present, w.wid);
        end
    endtask

    task automatic wait_drained();
        do @(posedge i_clk);
        while (req_words.size() != 0 || drv_valid || owed_results.size() != 0);
        repeat (3) @(posedge i_clk);
    endtask

    task automatic set_worker_limit(input logic [CFG_W-1:0] val);
        @(posedge i_clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {REG_MAX_WORKERS, 2'b00};
        pwdata <= APB_DATA_W'(val);
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk);
        while (!pready);
        pool_live.max_workers = val;
        pool_plan.max_workers = val;
        // read back straight after the write
        pwrite <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk);
        while (!pready);
        if (prdata[CFG_W-1:0] !== val) begin
            $display("%0t: max_workers read back expected %0d actual %0d",
                     $time, val, prdata[CFG_W-1:0]);
            n_errors++;
        end
        psel <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic check_field(input string what, input int want, input int got);
        if (want != got) begin
            $display("%0t: %s mismatch expected %0d actual %0d", $time, what, want, got);
            n_errors++;
        end
    endtask

    // sender: next word goes out once the current one is taken
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            drv_valid <= 1'b0;
        end else begin
            if (drv_valid && req_bus.ready) begin
                dispatch_word(pool_live, cur_word);
                while (step_out.size() != 0) owed_results.push_back(step_out.pop_front());
                if (pool_live.n_pending > peak_backlog) peak_backlog = pool_live.n_pending;
                n_accepted++;
            end
            if (!drv_valid || req_bus.ready) begin
                if (req_words.size() != 0 && $urandom_range(99) >= send_gap_pct) begin
                    cur_word <= req_words.pop_front();
                    drv_valid <= 1'b1;
                end else begin
                    drv_valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        drv_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    always @(posedge i_clk) begin
        rsp_word_t want;
        if (i_rst_n && rsp_bus.valid && rsp_bus.ready) begin
            if (owed_results.size() == 0) begin
                $display("%0t: unexpected result expected none actual status %0d worker %0d tag %h last %0d",
                         $time, rsp_bus.status, rsp_bus.out_worker, rsp_bus.out_tag,
                         rsp_bus.last);
                n_errors++;
            end else begin
                want = owed_results.pop_front();
                check_field("status", int'(want.status), int'(rsp_bus.status));
                check_field("out_worker", int'(want.worker), int'(rsp_bus.out_worker));
                check_field("out_tag", int'(want.tag), int'(rsp_bus.out_tag));
                check_field("last", int'(want.last), int'(rsp_bus.last));
                if (want.status == ST_ABORTED) n_aborted++;
                n_checked++;
            end
        end
    end

    initial begin
        #3000000;
        $display("worker_pool_dispatcher_tb: FAIL");
        $finish;
    end

    initial begin
        pool_live = '0;
        pool_live.max_workers = MAX_WORKERS_RESET;
        pool_plan = pool_live;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: rejects, ignores, creation up to the limit, backlog, lifo reuse
        push_word(FN_SUBMIT, 16'hFFFF, 1'b0, 4'h0);
        push_word(FN_FINISHED, 16'h0000, 1'b1, 4'h0);
        push_word(FN_UNDEF, 16'h0F0F, 1'b1, 4'hF);
        push_word(FN_SUBMIT, 16'h0000, 1'b1, 4'h0);
        push_word(FN_SUBMIT, 16'h1234, 1'b1, 4'h0);
        push_word(FN_SUBMIT, 16'h8000, 1'b1, 4'h0);
        push_word(FN_SUBMIT, 16'hABCD, 1'b1, 4'h0);
        push_word(FN_SUBMIT, 16'h5555, 1'b1, 4'h0);
        push_word(FN_SUBMIT, 16'hAAAA, 1'b1, 4'h0);
        push_word(FN_FINISHED, 16'h0000, 1'b1, 4'hF);
        push_word(FN_FINISHED, 16'h0000, 1'b1, 4'h2);
        push_word(FN_FINISHED, 16'h0000, 1'b1, 4'h1);
        push_word(FN_FINISHED, 16'h0000, 1'b1, 4'h1);
        push_word(FN_FINISHED, 16'h0000, 1'b1, 4'h1);
        push_word(FN_FINISHED, 16'hFFFF, 1'b1, 4'h3);
        push_word(FN_SUBMIT, 16'h7FFF, 1'b1, 4'h0);
        push_word(FN_SUBMIT, 16'hFFFE, 1'b1, 4'h0);
        wait_drained();

        set_worker_limit(5'd0);
        queue_random_words(65);
        wait_drained();

        send_gap_pct = 46;
        recv_stall_pct = 31;
        set_worker_limit(5'd31);
        queue_random_words(65);
        wait_drained();

        send_gap_pct = 0;
        recv_stall_pct = 0;
        set_worker_limit(5'd16);
        queue_random_words(60);
        wait_drained();

        // fill the backlog to the brim, overflow it, then shut down
        set_worker_limit(5'd1);
        while (pool_plan.n_pending < QDEPTH)
            push_word(FN_SUBMIT, TAG_W'($urandom), 1'b1, WID_W'($urandom));
        push_word(FN_SUBMIT, 16'hFFFF, 1'b1, 4'hF);
        push_word(FN_SHUTDOWN, 16'h0000, 1'b0, 4'h0);
        push_word(FN_SHUTDOWN, 16'hFFFF, 1'b1, 4'hF);
        push_word(FN_SUBMIT, 16'h4321, 1'b1, 4'h0);
        push_word(FN_FINISHED, 16'h0000, 1'b1, 4'h0);
        push_word(FN_UNDEF, 16'h0000, 1'b0, 4'h0);
        wait_drained();
        repeat (8) @(posedge i_clk);

        $display("covered %0d request words and %0d results over worker limits 4, 0, 31, 16, 1",
                 n_accepted, n_checked);
        $display("deepest backlog %0d tags, %0d tags aborted at shutdown",
                 peak_backlog, n_aborted);
        if (n_errors == 0 && owed_results.size() == 0) begin
            $display("worker_pool_dispatcher_tb: PASS");
        end else begin
            $display("worker_pool_dispatcher_tb: FAIL");
        end
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+src
src/wpd_pkg.sv
src/wpd_if.sv
src/wpd_ctrl.sv
src/wpd_dpath.sv
src/worker_pool_dispatcher.sv
tb/worker_pool_dispatcher_tb.sv
